// ===== src/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants for the first-free bitmap allocator: request and
// status codes, register indexes, bitmap word geometry and the
// controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // bitmap word geometry
    localparam int WORD_W    = 64;
    localparam int BIT_W     = 6;
    localparam int GRP_W     = 8;
    localparam int GRP_N     = WORD_W / GRP_W;
    localparam int IDX_W     = 12;
    localparam int CNT_W     = 13;
    localparam int IDX_LIMIT = 4096;

    // request codes
    localparam int REQ_W = 2;
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MARK  = 2'd2;

    // status codes
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_INDEX = 1'd1;

    // controller to datapath commands
    typedef struct packed {
        logic            load_req;
        logic            load_cand;
        logic            load_word;
        logic            rd_req;
        logic            rd_found;
        logic            wr;
        logic            retry;
        logic            set_res;
        logic [ST_W-1:0] res_st;
        logic            out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             in_range;
        logic             found;
        logic             word_past;
    } t_dp_stat;

    // lowest set bit of an 8-bit vector
    function automatic logic [2:0] ff8(input logic [7:0] v);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== src/bfa_ram.sv =====
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bfa_dp.sv =====
// ----------------------------------------------------------------------------
// bfa_dp
// Allocator datapath: configuration registers, request registers, bitmap
// word memory with per-row valid bits, per-word full summary, a two-level
// find-first unit shared by the word search and the bit search, and the
// result and output registers.
// ----------------------------------------------------------------------------
module bfa_dp #(
    parameter int CAP = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bfa_pkg::CNT_W-1:0]         i_cfg_data,
    input  logic [bfa_pkg::REQ_W-1:0]         i_req_type,
    input  logic [bfa_pkg::IDX_W-1:0]         i_index,
    input  bfa_pkg::t_dp_cmd                  i_cmd,
    output bfa_pkg::t_dp_stat                 o_stat,
    output logic [bfa_pkg::IDX_W-1:0]         o_result_index,
    output logic [bfa_pkg::ST_W-1:0]          o_status
);
    import bfa_pkg::*;

    localparam int NWORDS = (CAP + WORD_W - 1) / WORD_W;
    localparam int WW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int SW     = $clog2(NWORDS + 1);
    localparam int CW     = CNT_W - BIT_W;

    // configuration and request registers
    logic [CNT_W-1:0]  r_cnt;
    logic              r_first;
    logic [REQ_W-1:0]  r_req;
    logic [IDX_W-1:0]  r_idx;
    logic [WW-1:0]     r_word;
    logic [SW-1:0]     r_start;

    // find-first unit
    logic [WORD_W-1:0] r_vec;
    logic [GRP_N-1:0]  r_grp;

    // bitmap summary and row valid bits
    logic [NWORDS-1:0] r_full;
    logic [NWORDS-1:0] r_rowv;

    // result and output
    logic [IDX_W-1:0]  r_res_idx;
    logic [ST_W-1:0]   r_res_st;
    logic [IDX_W-1:0]  r_out_idx;
    logic [ST_W-1:0]   r_out_st;

    logic [CNT_W-1:0]  eff_cnt;
    logic [CW-1:0]     cnt_word;
    logic [BIT_W-1:0]  cnt_bit;
    logic [CW-1:0]     word_ext;
    logic [WORD_W-1:0] cand;
    logic [WORD_W-1:0] rd_data;
    logic [WORD_W-1:0] word_eff;
    logic [WORD_W-1:0] low_mask;
    logic [WORD_W-1:0] high_mask;
    logic [WORD_W-1:0] vec_src;
    logic [GRP_N-1:0]  grp_src;
    logic [2:0]        gsel;
    logic [GRP_W-1:0]  sel_byte;
    logic [2:0]        bsel;
    logic [BIT_W-1:0]  ff_pos;
    logic              found;
    logic [BIT_W-1:0]  wr_bit;
    logic [WORD_W-1:0] wr_onehot;
    logic [WORD_W-1:0] wdata;
    logic [WW-1:0]     rd_addr;
    logic [IDX_W-1:0]  n_res_idx;

    // effective entry count and its word/bit split
    assign eff_cnt  = (r_cnt > CNT_W'(CAP)) ? CNT_W'(CAP) : r_cnt;
    assign cnt_word = eff_cnt[CNT_W-1:BIT_W];
    assign cnt_bit  = eff_cnt[BIT_W-1:0];
    assign word_ext = CW'(r_word);

    // candidate words: not full and at or above the search start
    for (genvar gw = 0; gw < WORD_W; gw++) begin : g_cand
        if (gw < NWORDS) begin : g_live
            assign cand[gw] = !r_full[gw] && (SW'(gw) >= r_start);
        end else begin : g_pad
            assign cand[gw] = 1'b0;
        end
    end

    // bitmap word as stored, unwritten rows read as clear
    assign word_eff = r_rowv[r_word] ? rd_data : '0;

    // reserved entry zero and entries beyond the count look used
    assign low_mask = (r_word == '0 && r_first) ? WORD_W'(1) : '0;
    always_comb begin
        if (word_ext < cnt_word) begin
            high_mask = '0;
        end else if (word_ext == cnt_word) begin
            high_mask = ~((WORD_W'(1) << cnt_bit) - WORD_W'(1));
        end else begin
            high_mask = '1;
        end
    end

    // source of the find-first vector and its group summary
    assign vec_src = i_cmd.load_cand ? cand : ~(word_eff | low_mask | high_mask);
    always_comb begin
        for (int g = 0; g < GRP_N; g++) begin
            grp_src[g] = |vec_src[g*GRP_W +: GRP_W];
        end
    end

    // second level: pick group, then bit inside the group
    assign gsel     = ff8(r_grp);
    assign sel_byte = r_vec[gsel*GRP_W +: GRP_W];
    assign bsel     = ff8(sel_byte);
    assign ff_pos   = {gsel, bsel};
    assign found    = |r_grp;

    // read-modify-write data
    assign wr_bit    = (r_req == REQ_ALLOC) ? ff_pos : r_idx[BIT_W-1:0];
    assign wr_onehot = WORD_W'(1) << wr_bit;
    assign wdata     = (r_req == REQ_FREE) ? (word_eff & ~wr_onehot)
                                           : (word_eff | wr_onehot);
    assign rd_addr   = i_cmd.rd_found ? ff_pos[WW-1:0] : r_idx[BIT_W +: WW];

    bfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (r_word),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_req || i_cmd.rd_found),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // result value for the current transaction
    always_comb begin
        if (i_cmd.res_st == ST_FULL) begin
            n_res_idx = '0;
        end else if (r_req == REQ_ALLOC) begin
            n_res_idx = IDX_W'({r_word, ff_pos});
        end else begin
            n_res_idx = r_idx;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= CNT_W'(IDX_LIMIT);
            r_first <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENTRY_COUNT: r_cnt   <= i_cfg_data;
                CFG_FIRST_INDEX: r_first <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // bitmap summary and row valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
            r_rowv <= '0;
        end else if (i_cmd.wr) begin
            r_full[r_word] <= &wdata;
            r_rowv[r_word] <= 1'b1;
        end
    end

    // request, search and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req_type;
            r_idx <= i_index;
        end
        if (i_cmd.load_req) begin
            r_start <= '0;
        end else if (i_cmd.retry) begin
            r_start <= SW'(r_word) + SW'(1);
        end
        if (i_cmd.rd_req || i_cmd.rd_found) begin
            r_word <= rd_addr;
        end
        if (i_cmd.load_cand || i_cmd.load_word) begin
            r_vec <= vec_src;
            r_grp <= grp_src;
        end
        if (i_cmd.set_res) begin
            r_res_idx <= n_res_idx;
            r_res_st  <= i_cmd.res_st;
        end
        if (i_cmd.out_load) begin
            r_out_idx <= r_res_idx;
            r_out_st  <= r_res_st;
        end
    end

    assign o_stat.req       = r_req;
    assign o_stat.in_range  = {1'b0, r_idx} < eff_cnt;
    assign o_stat.found     = found;
    assign o_stat.word_past = word_ext >= cnt_word;

    assign o_result_index = r_out_idx;
    assign o_status       = r_out_st;

`ifndef ASSERT_OFF
    // an allocate only writes once a free bit was found
    a_alloc_wr_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr && r_req == REQ_ALLOC) |-> found)
        else $error("allocate wrote without a free bit");

    // full summary tracks the word just written
    a_full_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |=> (r_full[$past(r_word)] == (&$past(wdata))))
        else $error("full summary out of step with bitmap");

    // a granted index lies below the effective count
    a_alloc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.set_res && i_cmd.res_st == ST_OK && r_req == REQ_ALLOC)
            |-> ({1'b0, n_res_idx} < eff_cnt))
        else $error("allocated index beyond entry count");
`endif

endmodule

// ===== src/bfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfa_ctrl
// Allocator controller: sequences the word search, the bit search and the
// read-modify-write of the bitmap, and owns the input stall and the output
// valid flag.
// ----------------------------------------------------------------------------
module bfa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  bfa_pkg::t_dp_stat  i_stat,
    output bfa_pkg::t_dp_cmd   o_cmd
);
    import bfa_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_CGRP = 3'd2;
    localparam logic [2:0] S_WORD = 3'd3;
    localparam logic [2:0] S_WGRP = 3'd4;
    localparam logic [2:0] S_RMW  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;
    t_dp_cmd    cmd;

    assign accept = i_in_valid && (r_state == S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    cmd.load_req = 1'b1;
                    n_state      = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.req == REQ_ALLOC) begin
                    cmd.load_cand = 1'b1;
                    n_state       = S_CGRP;
                end else if ((i_stat.req == REQ_FREE || i_stat.req == REQ_MARK)
                             && i_stat.in_range) begin
                    cmd.rd_req = 1'b1;
                    n_state    = S_RMW;
                end else begin
                    cmd.set_res = 1'b1;
                    cmd.res_st  = ST_RANGE;
                    n_state     = S_DONE;
                end
            end
            S_CGRP: begin
                if (i_stat.found) begin
                    cmd.rd_found = 1'b1;
                    n_state      = S_WORD;
                end else begin
                    cmd.set_res = 1'b1;
                    cmd.res_st  = ST_FULL;
                    n_state     = S_DONE;
                end
            end
            S_WORD: begin
                cmd.load_word = 1'b1;
                n_state       = S_WGRP;
            end
            S_WGRP: begin
                if (i_stat.found) begin
                    cmd.wr      = 1'b1;
                    cmd.set_res = 1'b1;
                    cmd.res_st  = ST_OK;
                    n_state     = S_DONE;
                end else if (i_stat.word_past) begin
                    cmd.set_res = 1'b1;
                    cmd.res_st  = ST_FULL;
                    n_state     = S_DONE;
                end else begin
                    cmd.retry = 1'b1;
                    n_state   = S_DISP;
                end
            end
            S_RMW: begin
                cmd.wr      = 1'b1;
                cmd.set_res = 1'b1;
                cmd.res_st  = ST_OK;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

`ifndef ASSERT_OFF
    // an accepted transaction is dispatched next
    a_accept_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DISP))
        else $error("accepted transaction not dispatched");

    // the output register is only loaded when free or being drained
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result overwrote a pending result");

    // a settled result always goes to the output stage
    a_res_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.set_res |=> (r_state == S_DONE))
        else $error("result settled without delivery");
`endif

endmodule

// ===== src/bitmap_first_free_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// First-free bitmap allocator. Keeps one used bit per entry in 64-bit words
// with a per-word full summary; allocate returns the lowest clear entry from
// the configured first index below the entry count, free and mark clear or
// set a named entry.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_stall    i_req_type, i_index
//   out      output     o_out_valid / i_out_stall  o_result_index, o_status
//   cfg      input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// Allocate runs the word summary search, one registered bitmap RAM read
// and the bit search in the shared two-level find-first unit, and repeats
// them from the next word when entry zero is reserved and word zero has no
// other free entry; free and mark do one registered read and a write back,
// and rejected requests go straight to the result.
// One transaction is in flight at a time; a finished result waits in the
// output register while the next transaction runs up to its delivery.
// Reset is synchronous; row valid bits make the bitmap read as clear after
// reset with no clearing pass.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator #(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bfa_pkg::REQ_W-1:0]      i_req_type,
    input  logic [bfa_pkg::IDX_W-1:0]      i_index,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bfa_pkg::IDX_W-1:0]      o_result_index,
    output logic [bfa_pkg::ST_W-1:0]       o_status,
    input  logic                           i_cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bfa_pkg::CNT_W-1:0]      i_cfg_data
);
    import bfa_pkg::*;

    // entries actually held: result index width caps the map
    localparam int CAP = (MAX_ENTRIES < IDX_LIMIT) ? MAX_ENTRIES : IDX_LIMIT;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // controller
    bfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // datapath
    bfa_dp #(
        .CAP (CAP)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_req_type),
        .i_index        (i_index),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_result_index (o_result_index),
        .o_status       (o_status)
    );

endmodule

// ===== dv/bitmap_first_free_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_tb
// Self-checking bench for the first-free bitmap allocator. A queue-fed driver
// offers allocate, free, mark and undefined requests with random gaps. The
// bench keeps its own copy of the used bitmap and the two registers and works
// out the expected index and status for every accepted transaction. A monitor
// compares each delivered result against the oldest expected one. Registers
// are rewritten between phases once the block is idle; the sink stalls at
// random and once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_tb;
    import bfa_pkg::*;

    localparam int MAX_ENTRIES = 4096;
    localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;
    localparam int CLK_HALF = 10;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 153;
    localparam int PRESSURE_PHASE = 3;
    localparam int PRESSURE_CYCLES = 300;
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_REPORTS = 40;
    localparam longint TIME_LIMIT = 64'd20_000_000;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [IDX_W-1:0] index;
    } t_alloc_req;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [ST_W-1:0]  status;
    } t_alloc_rsp;

    // block ports
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [REQ_W-1:0]     req_type = '0;
    logic [IDX_W-1:0]     req_index = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [IDX_W-1:0]     result_index;
    logic [ST_W-1:0]      status;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]     cfg_data = '0;

    // shadow of the block state
    bit               used_bits [MAX_ENTRIES];
    logic [CNT_W-1:0] shadow_count = 13'd4096;
    logic             shadow_first = 1'b0;

    // request stream and results still owed by the block
    t_alloc_req request_queue [$];
    t_alloc_rsp awaited [$];

    // pacing controls written by the stimulus process
    logic steady = 1'b0;
    logic pressure_arm = 1'b0;

    int unsigned n_queued = 0;
    int unsigned n_accepted = 0;
    int unsigned n_alloc_ok = 0;
    int unsigned n_full = 0;
    int unsigned n_range = 0;
    int unsigned n_settings = 0;
    int unsigned mismatches = 0;

    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          pressure_done = 1'b0;
    t_alloc_req  next_req;
    t_alloc_req  seen_req;
    t_alloc_rsp  want;
    t_alloc_rsp  got;

    bitmap_first_free_allocator #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_req_type     (req_type),
        .i_index        (req_index),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_result_index (result_index),
        .o_status       (status),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // entries actually managed under the current register setting
    function automatic int unsigned live_count();
        int unsigned n;
        n = shadow_count;
        if (n > MAX_ENTRIES) begin
            n = MAX_ENTRIES;
        end
        if (n > IDX_LIMIT) begin
            n = IDX_LIMIT;
        end
        return n;
    endfunction

    // apply one request to the shadow bitmap and return the result it owes
    function automatic t_alloc_rsp apply_request(input t_alloc_req rq);
        t_alloc_rsp  rsp;
        int unsigned count;
        bit          found;
        count = live_count();
        found = 1'b0;
        rsp.index = rq.index;
        rsp.status = ST_OK;
        case (rq.req)
            REQ_ALLOC: begin
                rsp.index = '0;
                for (int unsigned i = shadow_first; i < count && !found; i++) begin
                    if (!used_bits[i]) begin
                        used_bits[i] = 1'b1;
                        rsp.index = IDX_W'(i);
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    rsp.status = ST_FULL;
                end
            end
            REQ_FREE, REQ_MARK: begin
                if (rq.index >= count) begin
                    rsp.status = ST_RANGE;
                end else begin
                    used_bits[rq.index] = (rq.req == REQ_MARK);
                end
            end
            default: begin
                rsp.status = ST_RANGE;
            end
        endcase
        return rsp;
    endfunction

    // idle length for either side: mostly none, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (steady) begin
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(3, 1);
        end
        if (roll < 97) begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS) begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
        mismatches++;
    endtask

    // driver: next request from the queue once the current one is taken
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (request_queue.size() > 0) begin
                next_req = request_queue.pop_front();
                in_valid <= 1'b1;
                req_type <= next_req.req;
                req_index <= next_req.index;
                send_gap = pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // sink stall: random runs, plus one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (pressure_arm && !pressure_done) begin
                pressure_done = 1'b1;
                hold_left = PRESSURE_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    // monitor: check the delivered result first, then predict the new one
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid === 1'b1 && !out_stall) begin
                if (awaited.size() == 0) begin
                    report_mismatch($sformatf("result index %0d status %0d with none awaited",
                                              result_index, status));
                end else begin
                    want = awaited.pop_front();
                    if (result_index !== want.index) begin
                        report_mismatch($sformatf("result_index %0d, expected %0d",
                                                  result_index, want.index));
                    end
                    if (status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                    end
                end
            end
            if (in_valid && !in_stall) begin
                seen_req.req = req_type;
                seen_req.index = req_index;
                got = apply_request(seen_req);
                awaited.push_back(got);
                n_accepted++;
                if (got.status == ST_RANGE) begin
                    n_range++;
                end else if (got.status == ST_FULL) begin
                    n_full++;
                end else if (seen_req.req == REQ_ALLOC) begin
                    n_alloc_ok++;
                end
            end
        end
    end

    task automatic add_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] index);
        request_queue.push_back('{req, index});
        n_queued++;
    endtask

    // block counts as idle once every queued transaction has been answered
    task automatic wait_idle();
        @(posedge clk);
        while (n_accepted != n_queued || awaited.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] which, input logic [CNT_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (which == CFG_ENTRY_COUNT) begin
            shadow_count = value;
        end else begin
            shadow_first = value[0];
        end
    endtask

    // upper data bits of the first index write are don't-care noise
    task automatic set_config(input logic [CNT_W-1:0] count, input logic first);
        write_reg(CFG_ENTRY_COUNT, count);
        write_reg(CFG_FIRST_INDEX, {(CNT_W-1)'($urandom), first});
        n_settings++;
    endtask

    // mostly small maps so that they fill and drain often
    function automatic logic [CNT_W-1:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 50) begin
            return CNT_W'($urandom_range(40, 1));
        end
        if (roll < 70) begin
            return CNT_W'($urandom_range(200, 56));
        end
        if (roll < 78) begin
            return CNT_W'(IDX_LIMIT);
        end
        if (roll < 86) begin
            return CNT_W'($urandom_range(8191, 4097));
        end
        if (roll < 90) begin
            return '0;
        end
        return CNT_W'($urandom_range(4096, 1));
    endfunction

    task automatic queue_random_phase(input int n);
        int unsigned count;
        int unsigned roll;
        int unsigned alloc_w;
        t_alloc_req  rq;
        count = live_count();
        alloc_w = $urandom_range(60, 35);
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            rq.index = IDX_W'($urandom);
            if (roll < alloc_w) begin
                rq.req = REQ_ALLOC;
            end else if (roll < 95) begin
                rq.req = (roll % 5 < 3) ? REQ_FREE : REQ_MARK;
            end else begin
                rq.req = REQ_UNDEF;
            end
            // free and mark mostly hit live entries, sometimes the edges
            if (rq.req != REQ_ALLOC) begin
                roll = $urandom_range(99);
                if (roll < 70 && count > 0) begin
                    rq.index = IDX_W'($urandom_range(count - 1));
                end else if (roll < 80) begin
                    rq.index = IDX_W'(count);
                end else if (roll < 85) begin
                    rq.index = '1;
                end
            end
            add_request(rq.req, rq.index);
        end
    endtask

    // stimulus
    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: first allocations, reuse, redundant free and mark
        add_request(REQ_ALLOC, '0);
        add_request(REQ_ALLOC, '1);
        add_request(REQ_ALLOC, 12'h555);
        add_request(REQ_FREE, 12'd1);
        add_request(REQ_ALLOC, 12'hAAA);
        add_request(REQ_MARK, 12'hFFF);
        add_request(REQ_FREE, 12'hFFF);
        add_request(REQ_FREE, 12'hFFF);
        add_request(REQ_MARK, 12'd0);
        add_request(REQ_UNDEF, 12'hABC);
        add_request(REQ_UNDEF, 12'h543);
        add_request(REQ_FREE, 12'hFFF);
        wait_idle();

        // zero entries: nothing to allocate and every index out of range
        set_config('0, 1'b0);
        add_request(REQ_ALLOC, '0);
        add_request(REQ_FREE, '0);
        add_request(REQ_MARK, 12'hFFF);
        wait_idle();

        // first index at the count
        set_config(13'd1, 1'b1);
        add_request(REQ_ALLOC, '0);
        wait_idle();

        // count above the limit is clamped, entry zero reserved
        set_config(13'h1FFF, 1'b1);
        add_request(REQ_ALLOC, '0);
        add_request(REQ_MARK, 12'hFFF);
        wait_idle();

        // single entry: fill, free, refill
        set_config(13'd1, 1'b0);
        add_request(REQ_ALLOC, '0);
        add_request(REQ_FREE, '0);
        add_request(REQ_ALLOC, '0);
        add_request(REQ_ALLOC, '0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            set_config(pick_count(), 1'($urandom));
            steady <= (p % 4 == 1);
            if (p == PRESSURE_PHASE) begin
                pressure_arm <= 1'b1;
            end
            queue_random_phase(ITEMS_PER_PHASE);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d requests over %0d register settings", n_accepted, n_settings + 1);
        $display("%0d allocations granted, %0d refused as full, %0d flagged out of range",
                 n_alloc_ok, n_full, n_range);
        if (mismatches == 0) begin
            $display("bitmap_first_free_allocator test passed");
        end else begin
            $display("bitmap_first_free_allocator test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIME_LIMIT);
        $display("timeout with %0d of %0d requests accepted, %0d results owed",
                 n_accepted, n_queued, awaited.size());
        $display("bitmap_first_free_allocator test failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/bfa_pkg.sv
src/bfa_ram.sv
src/bfa_dp.sv
src/bfa_ctrl.sv
src/bitmap_first_free_allocator.sv
dv/bitmap_first_free_allocator_tb.sv
